### rtl/directed_graph_edge_store_unit_macros.svh
// assertion macros shared by the edge store modules
`ifndef DIRECTED_GRAPH_EDGE_STORE_UNIT_MACROS_SVH
`define DIRECTED_GRAPH_EDGE_STORE_UNIT_MACROS_SVH

// same-cycle implication
`define DGES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edge store assertion failed");

// next-cycle implication
`define DGES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("edge store assertion failed");

`endif

### rtl/dges_pkg.sv
// package with types, codes and widths of the directed graph edge store
package dges_pkg;

   localparam int VERTICES_DEF = 16;
   localparam int FUNC_W       = 2;
   localparam int VERTEX_W     = 4;
   localparam int EDGE_COUNT_W = 9;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } fsm_state_type;

   typedef struct packed {
      logic capture;
      logic read;
      logic update;
   } ctrl_cmd_type;

endpackage

### rtl/dges_ctrl.sv
// controller state machine of the directed graph edge store
`include "directed_graph_edge_store_unit_macros.svh"

module dges_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dges_pkg::ctrl_cmd_type cmd
);

   dges_pkg::fsm_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_busy;

   assign out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dges_pkg::ST_IDLE: begin
            if (req_valid) state_in = dges_pkg::ST_READ;
         end
         dges_pkg::ST_READ: begin
            state_in = dges_pkg::ST_UPDATE;
         end
         dges_pkg::ST_UPDATE: begin
            if (!out_busy) state_in = dges_pkg::ST_IDLE;
         end
         default: begin
            state_in = dges_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.read    = 1'b0;
      cmd.update  = 1'b0;
      case (state_ff)
         dges_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         dges_pkg::ST_READ: begin
            cmd.read = 1'b1;
         end
         dges_pkg::ST_UPDATE: begin
            cmd.update = !out_busy;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dges_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `DGES_ASSERT_NEXT(a_accept_reads, clock, reset, req_valid && !req_stall, state_ff == dges_pkg::ST_READ)
   `DGES_ASSERT_IMPL(a_rsp_from_update, clock, reset, $rose(rsp_valid_ff), $past(state_ff == dges_pkg::ST_UPDATE))
   `DGES_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.update, !(rsp_valid_ff && rsp_stall))

endmodule

### rtl/dges_datapath.sv
// datapath of the directed graph edge store: row and column memories and counters
`include "directed_graph_edge_store_unit_macros.svh"

module dges_datapath #(
   parameter int VERTICES = dges_pkg::VERTICES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dges_pkg::ctrl_cmd_type             cmd,
   input  logic [dges_pkg::FUNC_W-1:0]        req_func,
   input  logic [dges_pkg::VERTEX_W-1:0]      req_from_vertex,
   input  logic [dges_pkg::VERTEX_W-1:0]      req_to_vertex,
   output logic                               rsp_changed,
   output logic                               rsp_edge_present,
   output logic [dges_pkg::EDGE_COUNT_W-1:0]  rsp_edge_count,
   output logic                               rsp_is_source,
   output logic                               rsp_is_sink,
   output logic                               rsp_is_symmetric
);

   localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
   localparam int EW = $clog2(VERTICES * VERTICES + 1);

   logic [dges_pkg::FUNC_W-1:0]   func_ff;
   logic [dges_pkg::VERTEX_W-1:0] from_ff, to_ff;

   logic [VERTICES-1:0] row_mem [VERTICES];
   logic [VERTICES-1:0] col_mem [VERTICES];
   logic [VERTICES-1:0] row_vld_ff, col_vld_ff;

   logic [VERTICES-1:0] row_v_ff, col_v_ff, col_w_ff;
   logic                row_v_vld_ff, col_v_vld_ff, col_w_vld_ff;

   logic [EW-1:0] total_ff, total_in;
   logic [EW-1:0] unmatched_ff, unmatched_in;

   logic [AW-1:0]       av, aw;
   logic                v_ok, w_ok, ok;
   logic [VERTICES-1:0] row_v, col_v, col_w, row_v_new, col_w_new, col_v_others;
   logic                has_vw, has_wv, ins, rem, chg, self_loop;

   assign av = AW'(from_ff);
   assign aw = AW'(to_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         from_ff <= req_from_vertex;
         to_ff   <= req_to_vertex;
      end
   end

   // memory read, registered
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         row_v_ff     <= row_mem[av];
         col_v_ff     <= col_mem[av];
         col_w_ff     <= col_mem[aw];
         row_v_vld_ff <= row_vld_ff[av];
         col_v_vld_ff <= col_vld_ff[av];
         col_w_vld_ff <= col_vld_ff[aw];
      end
   end

   always_comb begin
      v_ok      = 32'(from_ff) < VERTICES;
      w_ok      = 32'(to_ff) < VERTICES;
      ok        = v_ok && w_ok;
      row_v     = row_v_vld_ff ? row_v_ff : '0;
      col_v     = col_v_vld_ff ? col_v_ff : '0;
      col_w     = col_w_vld_ff ? col_w_ff : '0;
      has_vw    = ok && row_v[aw];
      has_wv    = ok && col_v[aw];
      ins       = ok && (func_ff == dges_pkg::FUNC_INSERT) && !has_vw;
      rem       = ok && (func_ff == dges_pkg::FUNC_REMOVE) && has_vw;
      chg       = ins || rem;
      self_loop = (av == aw);
      row_v_new = row_v;
      col_w_new = col_w;
      if (chg) begin
         row_v_new[aw] = ins;
         col_w_new[av] = ins;
      end
      col_v_others = col_v & ~({{(VERTICES-1){1'b0}}, 1'b1} << av);
      total_in     = total_ff;
      unmatched_in = unmatched_ff;
      if (ins) total_in = total_ff + EW'(1);
      else if (rem) total_in = total_ff - EW'(1);
      if (chg && !self_loop) begin
         if (ins ^ has_wv) unmatched_in = unmatched_ff + EW'(1);
         else unmatched_in = unmatched_ff - EW'(1);
      end
   end

   // memory write
   always_ff @(posedge clock) begin
      if (cmd.update && chg) begin
         row_mem[av] <= row_v_new;
         col_mem[aw] <= col_w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff   <= '0;
         col_vld_ff   <= '0;
         total_ff     <= '0;
         unmatched_ff <= '0;
      end else if (cmd.update) begin
         if (chg) begin
            row_vld_ff[av] <= 1'b1;
            col_vld_ff[aw] <= 1'b1;
         end
         total_ff     <= total_in;
         unmatched_ff <= unmatched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_changed      <= chg;
         rsp_edge_present <= ok && row_v_new[aw];
         rsp_edge_count   <= dges_pkg::EDGE_COUNT_W'(total_in);
         rsp_is_source    <= v_ok && (|row_v_new) && !(|col_v_others);
         rsp_is_sink      <= v_ok && !(|row_v_new) && (|col_v_others);
         rsp_is_symmetric <= (unmatched_in == '0);
      end
   end

   `DGES_ASSERT_NEXT(a_change_moves_total, clock, reset, cmd.update && chg, total_ff != $past(total_ff))
   `DGES_ASSERT_NEXT(a_pair_moves_unmatched, clock, reset, cmd.update && chg && !self_loop, unmatched_ff != $past(unmatched_ff))
   `DGES_ASSERT_NEXT(a_no_change_holds, clock, reset, cmd.update && !chg, $stable(total_ff) && $stable(unmatched_ff))

endmodule

### rtl/directed_graph_edge_store_unit.sv
// top level of the directed graph edge store
// an accepted request passes the read and update states before its response is registered
// a new request is taken only in the idle state, after the registered read of the
//   row and column memories and the update of the request before it
// the response register lets a new request enter while a response waits
// reset: synchronous; clears row and column valid bits and edge counters
module directed_graph_edge_store_unit #(
   parameter int VERTICES = dges_pkg::VERTICES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dges_pkg::FUNC_W-1:0]        req_func,
   input  logic [dges_pkg::VERTEX_W-1:0]      req_from_vertex,
   input  logic [dges_pkg::VERTEX_W-1:0]      req_to_vertex,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_changed,
   output logic                               rsp_edge_present,
   output logic [dges_pkg::EDGE_COUNT_W-1:0]  rsp_edge_count,
   output logic                               rsp_is_source,
   output logic                               rsp_is_sink,
   output logic                               rsp_is_symmetric
);

   dges_pkg::ctrl_cmd_type cmd;

   dges_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   dges_datapath #(
      .VERTICES (VERTICES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_func         (req_func),
      .req_from_vertex  (req_from_vertex),
      .req_to_vertex    (req_to_vertex),
      .rsp_changed      (rsp_changed),
      .rsp_edge_present (rsp_edge_present),
      .rsp_edge_count   (rsp_edge_count),
      .rsp_is_source    (rsp_is_source),
      .rsp_is_sink      (rsp_is_sink),
      .rsp_is_symmetric (rsp_is_symmetric)
   );

endmodule
